// ===== hw/rtl/base64_to_hex_decoder_defines.svh =====
// ---------------------------------------------------------------------------
// Base64 to hex decoder assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef BASE64_TO_HEX_DECODER_DEFINES_SVH
`define BASE64_TO_HEX_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Check that expr holds at every clock edge outside reset.
`define B64H_ASSERT_HOLDS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("b64h assertion failed");
// Check that cons holds whenever ante holds.
`define B64H_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64h assertion failed");
`else
`define B64H_ASSERT_HOLDS(label, expr)
`define B64H_ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

// ===== hw/rtl/b64h_pkg.sv =====
// ---------------------------------------------------------------------------
// Base64 to hex decoder package
// Shared types, constants and character mapping functions.
// ---------------------------------------------------------------------------
package b64h_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

  // One decoded group or one error, handed from front to back.
  typedef struct packed {
    logic        bad;
    logic [1:0]  nbytes;
    logic [23:0] bits;
  } job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  // Classification of one input character.
  typedef struct packed {
    logic       is_pad;
    logic       is_bad;
    logic [5:0] six;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.is_pad = 1'b0;
    r.is_bad = 1'b0;
    r.six    = 6'd0;
    if (c == CHAR_PAD) begin
      r.is_pad = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r.six = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.six = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.six = 6'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      r.six = 6'd62;
    end else if (c == CHAR_SLASH) begin
      r.six = 6'd63;
    end else begin
      r.is_bad = 1'b1;
    end
    return r;
  endfunction

  // Lower-case ASCII hex digit of one nibble.
  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'd0, n};
    end else begin
      r = 8'h61 + {4'd0, n} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/base64_to_hex_decoder.sv =====
// A character that completes a group passes through the work queue, the back's
//   job register and the output register before its first hex digit is valid.
// Throughput: one input character per cycle while the work queue has room;
//   the output register emits one hex character per cycle while out_stall is
//   low, and an unpadded group of four characters yields six hex characters.
// Reset: synchronous active-low rst_n empties the queue, the output register
//   and the partial group.
// ---------------------------------------------------------------------------
// Base64 to hex decoder top level
// Decodes base64 text into lower-case hex ASCII, one character per transfer.
// ---------------------------------------------------------------------------
module base64_to_hex_decoder #(
  parameter int QUEUE_DEPTH = b64h_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel: one base64 character per transfer.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  // Result channel: one hex character, or one error, per transfer.
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_hex_char,
  output logic       out_last_of_group,
  output logic       out_bad_char
);

  // Front to queue: finished groups and errors.
  logic              push;
  b64h_pkg::job_t    push_job;
  // Queue to back.
  logic              pop;
  b64h_pkg::job_t    pop_job;
  b64h_pkg::q_stat_t q_stat;

  // Classify each character and build the group; stall only when the queue is full.
  b64h_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .q_stat     (q_stat),
    .push       (push),
    .push_job   (push_job)
  );

  // Hold finished groups so the front keeps taking characters while the
  // back is still draining hex digits.
  b64h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // Expand each group into 2, 4 or 6 hex digits, or one error result;
  // advance to the next group on the same cycle the last digit loads.
  b64h_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .pop_job           (pop_job),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hex_char      (out_hex_char),
    .out_last_of_group (out_last_of_group),
    .out_bad_char      (out_bad_char)
  );

endmodule

// ===== hw/rtl/b64h_front.sv =====
// ---------------------------------------------------------------------------
// Base64 to hex decoder front
// Accepts characters, builds 24-bit groups and queues finished work.
// ---------------------------------------------------------------------------
module b64h_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_char_in,
  input  b64h_pkg::q_stat_t q_stat,
  output logic              push,
  output b64h_pkg::job_t    push_job
);

  logic [23:0] group_r, group_nxt;
  logic [1:0]  chars_r, chars_nxt;
  logic [2:0]  pad_r, pad_nxt, pad_inc;
  logic        accept;
  logic [1:0]  nbytes;
  b64h_pkg::char_class_t cls;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cls       = b64h_pkg::classify(in_char_in);
    pad_inc   = (cls.is_pad && pad_r != 3'd7) ? pad_r + 3'd1 : pad_r;
    nbytes    = (pad_inc >= 3'd3) ? 2'd0 : 2'(3'd3 - pad_inc);
    group_nxt = group_r;
    chars_nxt = chars_r;
    pad_nxt   = pad_r;
    push      = 1'b0;
    push_job.bad    = 1'b0;
    push_job.nbytes = nbytes;
    push_job.bits   = {group_r[17:0], cls.six};
    if (accept) begin
      if (cls.is_bad) begin
        // Drop the partial group and report one error.
        group_nxt       = 24'd0;
        chars_nxt       = 2'd0;
        pad_nxt         = 3'd0;
        push            = 1'b1;
        push_job.bad    = 1'b1;
        push_job.nbytes = 2'd0;
        push_job.bits   = 24'd0;
      end else if (chars_r == 2'd3) begin
        group_nxt = 24'd0;
        chars_nxt = 2'd0;
        pad_nxt   = 3'd0;
        push      = (nbytes != 2'd0);
      end else begin
        group_nxt = {group_r[17:0], cls.six};
        chars_nxt = chars_r + 2'd1;
        pad_nxt   = pad_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= 24'd0;
      chars_r <= 2'd0;
      pad_r   <= 3'd0;
    end else begin
      group_r <= group_nxt;
      chars_r <= chars_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

// ===== hw/rtl/b64h_queue.sv =====
// ---------------------------------------------------------------------------
// Base64 to hex decoder work queue
// Small FIFO of finished groups and errors between front and back.
// ---------------------------------------------------------------------------
`include "base64_to_hex_decoder_defines.svh"

module b64h_queue #(
  parameter int DEPTH = b64h_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64h_pkg::job_t    push_job,
  input  logic              pop,
  output b64h_pkg::job_t    pop_job,
  output b64h_pkg::q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64h_pkg::job_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full      = (count_r == CNT_W'(DEPTH));
  assign q_stat.not_empty = (count_r != '0);
  assign pop_job          = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  `B64H_ASSERT_IMPLIES(a_no_push_full, push, !q_stat.full)
  `B64H_ASSERT_IMPLIES(a_no_pop_empty, pop, q_stat.not_empty)
  `B64H_ASSERT_HOLDS(a_count_range, count_r <= CNT_W'(DEPTH))

endmodule

// ===== hw/rtl/b64h_back.sv =====
// ---------------------------------------------------------------------------
// Base64 to hex decoder back
// Expands queued groups into hex characters through an output register.
// ---------------------------------------------------------------------------
`include "base64_to_hex_decoder_defines.svh"

module b64h_back (
  input  logic              clk,
  input  logic              rst_n,
  input  b64h_pkg::q_stat_t q_stat,
  input  b64h_pkg::job_t    pop_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_hex_char,
  output logic              out_last_of_group,
  output logic              out_bad_char
);

  b64h_pkg::job_t job_r;
  logic       active_r, active_nxt;
  logic [2:0] digit_r, digit_nxt, last_idx;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_hex_char_r;
  logic       out_last_r, out_bad_r;
  logic       out_load, finishing;
  logic [3:0] nibble;

  assign last_idx  = {job_r.nbytes, 1'b0} - 3'd1;
  assign finishing = job_r.bad || (digit_r == last_idx);
  assign out_load  = active_r && (!out_valid_r || !out_stall);
  assign pop       = q_stat.not_empty && (!active_r || (out_load && finishing));

  always_comb begin
    case (digit_r)
      3'd0:    nibble = job_r.bits[23:20];
      3'd1:    nibble = job_r.bits[19:16];
      3'd2:    nibble = job_r.bits[15:12];
      3'd3:    nibble = job_r.bits[11:8];
      3'd4:    nibble = job_r.bits[7:4];
      3'd5:    nibble = job_r.bits[3:0];
      default: nibble = 4'd0;
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    digit_nxt  = digit_r;
    if (pop) begin
      active_nxt = 1'b1;
      digit_nxt  = 3'd0;
    end else if (out_load && finishing) begin
      active_nxt = 1'b0;
    end else if (out_load) begin
      digit_nxt = digit_r + 3'd1;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      digit_r     <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      digit_r     <= digit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= pop_job;
    end
    if (out_load) begin
      out_hex_char_r <= job_r.bad ? 8'd0 : b64h_pkg::hex_ascii(nibble);
      out_last_r     <= !job_r.bad && finishing;
      out_bad_r      <= job_r.bad;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hex_char      = out_hex_char_r;
  assign out_last_of_group = out_last_r;
  assign out_bad_char      = out_bad_r;

  `B64H_ASSERT_IMPLIES(a_bad_not_last, out_valid_r && out_bad_r, !out_last_r)

endmodule
